// ===== src/vmcc_pkg.sv =====
// ----------------------------------------------------------------------------
// vmcc_pkg
// Shared types and constants for the voice mixer with clip and convert.
// ----------------------------------------------------------------------------
package vmcc_pkg;

  localparam int SAFE_SHIFT = 3;

  localparam int SAMPLE_W = 16;
  localparam int VOL_W    = 12;
  localparam int PROD_W   = SAMPLE_W + VOL_W + 1;
  localparam int ACC_W    = 36;
  localparam int CLIP_W   = 32 - SAFE_SHIFT;
  localparam int OUT_W    = 16;
  localparam int FMT_W    = 2;

  localparam int SHIFT8  = 24 - SAFE_SHIFT;
  localparam int SHIFT16 = 16 - SAFE_SHIFT;

  localparam logic signed [ACC_W-1:0] CLIP_MAX =
    ACC_W'((64'sd1 <<< (31 - SAFE_SHIFT)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] CLIP_MIN = -CLIP_MAX;

  localparam logic [7:0]  SIGN8  = 8'h80;
  localparam logic [15:0] SIGN16 = 16'h8000;

  typedef enum logic [FMT_W-1:0] {
    FMT_U8  = 2'd0,
    FMT_S8  = 2'd1,
    FMT_U16 = 2'd2,
    FMT_S16 = 2'd3
  } fmt_e;

  typedef enum logic {
    REG_FORMAT = 1'b0,
    REG_STEREO = 1'b1
  } reg_idx_e;

endpackage

// ===== src/voice_mix_clip_convert.sv =====
// ----------------------------------------------------------------------------
// voice_mix_clip_convert
// Mixes voice samples into saturating accumulators, emits a clipped frame.
// ----------------------------------------------------------------------------
// channel | dir | word
// s_axis  | in  | tdata: sample_left, sample_right, volume_left, volume_right
//         |     | tlast: last_voice
// m_axis  | out | tdata: out_left, out_right
// cfg     | in  | index 0 output_format, index 1 stereo_mode
//
// One word per cycle while no stage stalls. A last voice word reaches its frame word
// through the input reg, product reg, frame reg (accumulated into it) and output reg.
// Reset clears valids, accumulators and config (format signed 16, stereo on).
// Each stage holds when the one after it is full and stalled; non-last words
// keep flowing while a frame word waits on the master side.
// ----------------------------------------------------------------------------
module voice_mix_clip_convert (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [15:0] sample_left, [31:16] sample_right, [43:32] volume_left,
  // [55:44] volume_right
  input  logic [55:0] s_axis_tdata_i,
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [15:0] out_left, [31:16] out_right
  output logic [31:0] m_axis_tdata_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [1:0]  cfg_data_i
);
  import vmcc_pkg::*;

  // config
  fmt_e fmt_q;
  logic stereo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FMT_S16;
      stereo_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_FORMAT: fmt_q    <= fmt_e'(cfg_data_i);
        REG_STEREO: stereo_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // stage valids and handshake chain
  logic a_valid_q, b_valid_q, f_valid_q, o_valid_q;
  logic a_last_q, b_last_q;
  logic o_free, f_free, b_adv, b_free, a_free;

  assign o_free = !o_valid_q || m_axis_tready_i;
  assign f_free = !f_valid_q || o_free;
  assign b_adv  = b_valid_q && (!b_last_q || f_free);
  assign b_free = !b_valid_q || b_adv;
  assign a_free = !a_valid_q || b_free;

  assign s_axis_tready_o = a_free;
  assign m_axis_tvalid_o = o_valid_q;

  // input register
  logic signed [SAMPLE_W-1:0] a_sl_q, a_sr_q;
  logic        [VOL_W-1:0]    a_vl_q, a_vr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_free) begin
      a_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_free && s_axis_tvalid_i) begin
      a_sl_q   <= s_axis_tdata_i[15:0];
      a_sr_q   <= s_axis_tdata_i[31:16];
      a_vl_q   <= s_axis_tdata_i[43:32];
      a_vr_q   <= s_axis_tdata_i[55:44];
      a_last_q <= s_axis_tlast_i;
    end
  end

  // product register
  logic signed [PROD_W-1:0] b_pl_q, b_pr_q, b_pl_d, b_pr_d;

  assign b_pl_d = PROD_W'(a_sl_q * $signed({1'b0, a_vl_q}));
  assign b_pr_d = PROD_W'(a_sr_q * $signed({1'b0, a_vr_q}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_free) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_free && a_valid_q) begin
      b_pl_q   <= b_pl_d;
      b_pr_q   <= b_pr_d;
      b_last_q <= a_last_q;
    end
  end

  // accumulate with saturation
  localparam logic signed [ACC_W:0] ACC_MAX = {2'b00, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W:0] ACC_MIN = {2'b11, {(ACC_W-1){1'b0}}};

  logic signed [ACC_W-1:0] acc_l_q, acc_r_q, sum_l, sum_r;
  logic signed [ACC_W:0]   raw_l, raw_r;

  always_comb begin
    raw_l = {acc_l_q[ACC_W-1], acc_l_q} + (ACC_W+1)'(b_pl_q);
    raw_r = {acc_r_q[ACC_W-1], acc_r_q} + (ACC_W+1)'(b_pr_q);
    if (raw_l > ACC_MAX) begin
      sum_l = ACC_MAX[ACC_W-1:0];
    end else if (raw_l < ACC_MIN) begin
      sum_l = ACC_MIN[ACC_W-1:0];
    end else begin
      sum_l = raw_l[ACC_W-1:0];
    end
    if (!stereo_q) begin
      sum_r = acc_r_q;
    end else if (raw_r > ACC_MAX) begin
      sum_r = ACC_MAX[ACC_W-1:0];
    end else if (raw_r < ACC_MIN) begin
      sum_r = ACC_MIN[ACC_W-1:0];
    end else begin
      sum_r = raw_r[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_l_q <= '0;
      acc_r_q <= '0;
    end else if (b_adv) begin
      acc_l_q <= b_last_q ? '0 : sum_l;
      acc_r_q <= b_last_q ? '0 : sum_r;
    end
  end

  // frame register
  logic signed [ACC_W-1:0] f_l_q, f_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (f_free) begin
      f_valid_q <= b_adv && b_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv && b_last_q) begin
      f_l_q <= sum_l;
      f_r_q <= sum_r;
    end
  end

  // convert and output register
  logic [OUT_W-1:0] o_l_d, o_r_d, o_l_q, o_r_q;

  vmcc_fmt u_fmt_l (
    .sum_i (f_l_q),
    .fmt_i (fmt_q),
    .en_i  (1'b1),
    .out_o (o_l_d)
  );

  vmcc_fmt u_fmt_r (
    .sum_i (f_r_q),
    .fmt_i (fmt_q),
    .en_i  (stereo_q),
    .out_o (o_r_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (o_free) begin
      o_valid_q <= f_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_free && f_valid_q) begin
      o_l_q <= o_l_d;
      o_r_q <= o_r_d;
    end
  end

  assign m_axis_tdata_o = {o_r_q, o_l_q};

`ifndef SYNTHESIS
  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_adv && b_last_q) |=> (acc_l_q == '0 && acc_r_q == '0))
    else $error("accumulators not cleared after frame end");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (a_valid_q && b_valid_q && b_last_q && f_valid_q && o_valid_q))
    else $error("input stalled with a free stage");

  a_frame_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_valid_q && !o_free) |=> (f_valid_q && $stable(f_l_q) && $stable(f_r_q)))
    else $error("frame word lost while output stalled");
`endif

endmodule

// ===== src/vmcc_fmt.sv =====
// ----------------------------------------------------------------------------
// vmcc_fmt
// Clips one accumulator to the safe range and converts it to the output format;
// drives zero when en_i is low.
module vmcc_fmt (
  input  logic signed [vmcc_pkg::ACC_W-1:0] sum_i,
  input  vmcc_pkg::fmt_e                    fmt_i,
  input  logic                              en_i,
  output logic [vmcc_pkg::OUT_W-1:0]        out_o
);
  import vmcc_pkg::*;

  logic signed [ACC_W-1:0]  clip_full;
  logic        [CLIP_W-1:0] clip;
  logic        [7:0]        v8;
  logic        [15:0]       v16;

  always_comb begin
    if (sum_i > CLIP_MAX) begin
      clip_full = CLIP_MAX;
    end else if (sum_i < CLIP_MIN) begin
      clip_full = CLIP_MIN;
    end else begin
      clip_full = sum_i;
    end
    clip = clip_full[CLIP_W-1:0];
    v8   = clip[SHIFT8 +: 8];
    v16  = clip[SHIFT16 +: 16];
    case (fmt_i)
      FMT_U8:  out_o = {8'd0, v8 ^ SIGN8};
      FMT_S8:  out_o = {8'd0, v8};
      FMT_U16: out_o = v16 ^ SIGN16;
      default: out_o = v16;
    endcase
    if (!en_i) begin
      out_o = '0;
    end
  end

endmodule
